// ----- rtl/go_back_n_sender_window_unit_defines.svh -----
// assertion macros for the go-back-n sender window unit
// used by the top level only, expects clk and rst_n in scope
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH

// same-cycle implication
`define GBN_ASSERT_NOW(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("go-back-n sender check failed");

// next-cycle implication
`define GBN_ASSERT_NEXT(label, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("go-back-n sender check failed");

`endif

// ----- rtl/gbn_pkg.sv -----
// types and codes of the go-back-n sender window unit
// no dependencies
`default_nettype none

package gbn_pkg;

    localparam int SLOT_W  = 4;
    localparam int BYTES_W = 11;

    localparam logic [1:0] ACT_ENQ   = 2'd0;
    localparam logic [1:0] ACT_ACK   = 2'd1;
    localparam logic [1:0] ACT_CLOSE = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    localparam logic [2:0] STAT_OK       = 3'd0;
    localparam logic [2:0] STAT_FULL     = 3'd1;
    localparam logic [2:0] STAT_NONEMPTY = 3'd2;
    localparam logic [2:0] STAT_CLOSED   = 3'd3;
    localparam logic [2:0] STAT_IGNORED  = 3'd4;

    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_FIN_LIMIT = 2'd1;
    localparam logic [1:0] CFG_INIT_SEQ  = 2'd2;

    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [31:0]        seq;
        logic [BYTES_W-1:0] bytes;
        logic               fin;
    } gbn_entry_t;

    typedef struct packed {
        logic               kind;
        logic [SLOT_W-1:0]  slot;
        logic [31:0]        seq;
        logic [BYTES_W-1:0] bytes;
        logic               fin;
        logic [2:0]         status;
        logic               last;
    } gbn_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SEND_NEW,
        S_ACK_CHK,
        S_ACK_SEND,
        S_ACK_WAIT,
        S_TICK_RD,
        S_TICK_SEND,
        S_FINISH
    } gbn_state_t;

endpackage

`default_nettype wire

// ----- rtl/gbn_if.sv -----
// channel interfaces: event input, result output, register writes
// depends on gbn_pkg
`default_nettype none

interface gbn_item_if
    import gbn_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [10:0] packet_bytes;
    logic [31:0] ack_seq;
    logic        ack_flag;
    logic        fin_flag;
    modport source (output valid, action, packet_bytes, ack_seq, ack_flag, fin_flag,
                    input ready);
    modport sink (input valid, action, packet_bytes, ack_seq, ack_flag, fin_flag,
                  output ready);
endinterface

interface gbn_result_if
    import gbn_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [SLOT_W-1:0]  slot;
    logic [31:0]        seq;
    logic [BYTES_W-1:0] bytes;
    logic               fin;
    logic [2:0]         status;
    logic               last;
    modport source (output valid, kind, slot, seq, bytes, fin, status, last, input ready);
    modport sink (input valid, kind, slot, seq, bytes, fin, status, last, output ready);
endinterface

interface gbn_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/gbn_ring.sv -----
// descriptor ring memory, one write and one registered read port
// depends on gbn_pkg
`default_nettype none

module gbn_ring
    import gbn_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire gbn_entry_t               wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      gbn_entry_t               rd_data
);

    gbn_entry_t mem [DEPTH];
    gbn_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/go_back_n_sender_window_unit.sv -----
// go-back-n sender window unit: top level with the control sequencer
// depends on gbn_pkg, gbn_if, gbn_ring and the assertion macro header
//
// usage
// item: one event per transaction (enqueue, ack, close, timer tick).
// result: zero or more transmit orders (kind 0) then one status (kind 1, last 1).
// cfg: register writes (0 timeout, 1 fin retry limit, 2 initial sequence), taken
// at once; write only while the unit is idle.
// one event at a time; item ready is high only between events.
// an enqueue inside the window or a close sends its packet before the status result.
// ack: retires acked packets one at a time, each through a check and a wait state,
// and sends the packet at the window edge when more than the window is queued.
// tick with timeout: resends the packets of the window one at a time.
// the steps are set by the single read port of the ring memory, whose read data
// is registered.
// a result waits in the output register; when result ready is low the
// sequencer holds before loading the next result.
// reset: ring empty, head 0, timer and fin count 0, open, registers at
// 1000, 10 and 0; ring contents are left undefined.
`default_nettype none
`include "go_back_n_sender_window_unit_defines.svh"

module go_back_n_sender_window_unit
    import gbn_pkg::*;
#(
    parameter int BUFFER_SLOTS = 16,
    parameter int WINDOW       = 8,
    parameter int PACKET_BYTES = 1024
) (
    input wire logic    clk,
    input wire logic    rst_n,
    gbn_item_if.sink    item,
    gbn_result_if.source result,
    gbn_cfg_if.sink     cfg
);

    localparam int IW = $clog2(BUFFER_SLOTS);
    localparam int CW = $clog2(BUFFER_SLOTS + 1);
    localparam logic [BYTES_W-1:0] CAP =
        BYTES_W'(PACKET_BYTES > 2047 ? 2047 : PACKET_BYTES);

    function automatic logic [IW-1:0] wrap(input logic [IW+1:0] x);
        logic [IW+1:0] y;
        y = (x >= (IW+2)'(BUFFER_SLOTS)) ? x - (IW+2)'(BUFFER_SLOTS) : x;
        return y[IW-1:0];
    endfunction

    gbn_state_t state_reg, state_next;

    logic [1:0]         act_reg;
    logic [BYTES_W-1:0] pbytes_reg;
    logic [31:0]        ackn_reg;
    logic               ackf_reg, finf_reg;

    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   next_seq_reg, next_seq_next;
    logic [15:0]   timer_reg, timer_next;
    logic [7:0]    fin_count_reg, fin_count_next;
    logic          closed_reg, closed_next;
    logic [31:0]   span_reg, span_next;
    logic [CW-1:0] k_reg, k_next;
    gbn_res_t      res_reg, res_next;

    logic [15:0] timeout_reg;
    logic [7:0]  fin_limit_reg;

    gbn_res_t out_reg, out_next;
    logic     out_valid_reg, out_valid_next;
    logic     out_free;

    logic          wr_en;
    logic [IW-1:0] wr_addr;
    gbn_entry_t    wr_data;
    logic [IW-1:0] rd_addr;
    gbn_entry_t    rd_data;

    logic [IW-1:0] tail;
    logic [31:0]   d_ack;
    logic [15:0]   timer_inc;
    logic [7:0]    fin_inc;
    logic          ack_hit;

    gbn_ring #(.DEPTH(BUFFER_SLOTS)) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign cfg.ready  = 1'b1;
    assign out_free   = !out_valid_reg || result.ready;

    assign result.valid  = out_valid_reg;
    assign result.kind   = out_reg.kind;
    assign result.slot   = out_reg.slot;
    assign result.seq    = out_reg.seq;
    assign result.bytes  = out_reg.bytes;
    assign result.fin    = out_reg.fin;
    assign result.status = out_reg.status;
    assign result.last   = out_reg.last;

    assign tail      = wrap((IW+2)'(head_reg) + (IW+2)'(count_reg));
    assign d_ack     = ackn_reg - rd_data.seq;
    assign timer_inc = (timer_reg == 16'hFFFF) ? timer_reg : timer_reg + 16'd1;
    assign fin_inc   = (rd_data.fin && fin_count_reg != 8'hFF) ? fin_count_reg + 8'd1
                                                               : fin_count_reg;
    assign ack_hit   = (count_reg != '0) && ((d_ack - 32'd1) < span_reg);

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        next_seq_next  = next_seq_reg;
        timer_next     = timer_reg;
        fin_count_next = fin_count_reg;
        closed_next    = closed_reg;
        span_next      = span_reg;
        k_next         = k_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        wr_en          = 1'b0;
        wr_addr        = tail;
        wr_data        = '0;
        rd_addr        = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                res_next   = '0;
                res_next.kind = KIND_STATUS;
                res_next.last = 1'b1;
                state_next = S_FINISH;
                if (closed_reg)
                begin
                    res_next.status = STAT_CLOSED;
                end
                else
                begin
                    unique case (act_reg)
                        ACT_ENQ:
                        begin
                            if (pbytes_reg == '0)
                            begin
                                res_next.status = STAT_IGNORED;
                            end
                            else if (count_reg != '0 && rd_data.fin)
                            begin
                                res_next.status = STAT_CLOSED;
                            end
                            else if (int'(count_reg) >= BUFFER_SLOTS)
                            begin
                                res_next.status = STAT_FULL;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_data.seq   = next_seq_reg;
                                wr_data.bytes = (pbytes_reg > CAP) ? CAP : pbytes_reg;
                                wr_data.fin   = 1'b0;
                                if (count_reg == '0)
                                begin
                                    timer_next = '0;
                                end
                                res_next.slot  = SLOT_W'(tail);
                                res_next.seq   = next_seq_reg;
                                res_next.bytes = wr_data.bytes;
                                res_next.status = STAT_OK;
                                next_seq_next  = next_seq_reg + 32'd1;
                                count_next     = count_reg + CW'(1);
                                if (int'(count_reg) < WINDOW)
                                begin
                                    state_next = S_SEND_NEW;
                                end
                            end
                        end
                        ACT_ACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STAT_IGNORED;
                            end
                            else if (ackf_reg && finf_reg)
                            begin
                                closed_next     = 1'b1;
                                res_next.status = STAT_CLOSED;
                            end
                            else if (!ackf_reg || d_ack == '0 ||
                                     d_ack > (next_seq_reg - rd_data.seq))
                            begin
                                res_next.status = STAT_IGNORED;
                            end
                            else
                            begin
                                span_next  = next_seq_reg - rd_data.seq;
                                state_next = S_ACK_CHK;
                            end
                        end
                        ACT_CLOSE:
                        begin
                            if (count_reg != '0)
                            begin
                                res_next.status = STAT_NONEMPTY;
                            end
                            else
                            begin
                                wr_en          = 1'b1;
                                wr_data.seq    = next_seq_reg;
                                wr_data.fin    = 1'b1;
                                timer_next     = '0;
                                fin_count_next = '0;
                                res_next.slot  = SLOT_W'(tail);
                                res_next.seq   = next_seq_reg;
                                res_next.fin   = 1'b1;
                                res_next.status = STAT_OK;
                                next_seq_next  = next_seq_reg + 32'd1;
                                count_next     = count_reg + CW'(1);
                                state_next     = S_SEND_NEW;
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STAT_IGNORED;
                            end
                            else if (timer_inc > timeout_reg)
                            begin
                                timer_next     = '0;
                                fin_count_next = fin_inc;
                                k_next         = '0;
                                state_next     = S_TICK_RD;
                            end
                            else
                            begin
                                timer_next = timer_inc;
                                if (fin_count_reg > fin_limit_reg)
                                begin
                                    closed_next     = 1'b1;
                                    res_next.status = STAT_CLOSED;
                                end
                                else
                                begin
                                    res_next.status = STAT_OK;
                                end
                            end
                        end
                    endcase
                end
            end
            S_SEND_NEW:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_next        = res_reg;
                    out_next.kind   = KIND_SEND;
                    out_next.status = STAT_OK;
                    out_next.last   = 1'b0;
                    state_next      = S_FINISH;
                end
            end
            S_ACK_CHK:
            begin
                if (ack_hit)
                begin
                    if (int'(count_reg) > WINDOW)
                    begin
                        rd_addr    = wrap((IW+2)'(head_reg) + (IW+2)'(WINDOW));
                        state_next = S_ACK_SEND;
                    end
                    else
                    begin
                        head_next  = wrap((IW+2)'(head_reg) + (IW+2)'(1));
                        count_next = count_reg - CW'(1);
                        state_next = S_ACK_WAIT;
                    end
                end
                else
                begin
                    timer_next      = '0;
                    res_next.status = STAT_OK;
                    state_next      = S_FINISH;
                end
            end
            S_ACK_SEND:
            begin
                rd_addr = wrap((IW+2)'(head_reg) + (IW+2)'(WINDOW));
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.kind  = KIND_SEND;
                    out_next.slot  = SLOT_W'(wrap((IW+2)'(head_reg) + (IW+2)'(WINDOW)));
                    out_next.seq   = rd_data.seq;
                    out_next.bytes = rd_data.bytes;
                    out_next.fin   = rd_data.fin;
                    head_next      = wrap((IW+2)'(head_reg) + (IW+2)'(1));
                    count_next     = count_reg - CW'(1);
                    state_next     = S_ACK_WAIT;
                end
            end
            S_ACK_WAIT:
            begin
                state_next = S_ACK_CHK;
            end
            S_TICK_RD:
            begin
                rd_addr    = wrap((IW+2)'(head_reg) + (IW+2)'(k_reg));
                state_next = S_TICK_SEND;
            end
            S_TICK_SEND:
            begin
                rd_addr = wrap((IW+2)'(head_reg) + (IW+2)'(k_reg));
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.kind  = KIND_SEND;
                    out_next.slot  = SLOT_W'(rd_addr);
                    out_next.seq   = rd_data.seq;
                    out_next.bytes = rd_data.bytes;
                    out_next.fin   = rd_data.fin;
                    k_next         = k_reg + CW'(1);
                    if (int'(k_reg) + 1 >= WINDOW || k_reg + CW'(1) == count_reg)
                    begin
                        state_next = S_FINISH;
                        if (fin_count_reg > fin_limit_reg)
                        begin
                            closed_next     = 1'b1;
                            res_next.status = STAT_CLOSED;
                        end
                        else
                        begin
                            res_next.status = STAT_OK;
                        end
                    end
                    else
                    begin
                        state_next = S_TICK_RD;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg.valid && cfg.index == CFG_INIT_SEQ)
        begin
            next_seq_next = cfg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            next_seq_reg  <= '0;
            timer_reg     <= '0;
            fin_count_reg <= '0;
            closed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= 16'd1000;
            fin_limit_reg <= 8'd10;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            next_seq_reg  <= next_seq_next;
            timer_reg     <= timer_next;
            fin_count_reg <= fin_count_next;
            closed_reg    <= closed_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid && cfg.index == CFG_TIMEOUT)
            begin
                timeout_reg <= cfg.data[15:0];
            end
            if (cfg.valid && cfg.index == CFG_FIN_LIMIT)
            begin
                fin_limit_reg <= cfg.data[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        k_reg    <= k_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
        if (state_reg == S_IDLE && item.valid)
        begin
            act_reg    <= item.action;
            pbytes_reg <= item.packet_bytes;
            ackn_reg   <= item.ack_seq;
            ackf_reg   <= item.ack_flag;
            finf_reg   <= item.fin_flag;
        end
    end

    `GBN_ASSERT_NOW(a_count_bound, 1'b1, int'(count_reg) <= BUFFER_SLOTS)
    `GBN_ASSERT_NEXT(a_closed_sticky, closed_reg, closed_reg)
    `GBN_ASSERT_NOW(a_write_only_decide, wr_en, state_reg == S_DECIDE)
    `GBN_ASSERT_NOW(a_send_needs_packet, state_reg == S_ACK_SEND || state_reg == S_TICK_SEND,
                    count_reg != '0)

endmodule

`default_nettype wire
